### hdl/clamped_softmax_mass_distributor_defines.svh
// assertion macros shared by the mass distributor rtl
`ifndef CLAMPED_SOFTMAX_MASS_DISTRIBUTOR_DEFINES_SVH
`define CLAMPED_SOFTMAX_MASS_DISTRIBUTOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define CSMD_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define CSMD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CSMD_ASSERT(lbl, expr, msg)
`define CSMD_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

### hdl/csmd_pkg.sv
// types and constants of the mass distributor
package csmd_pkg;
	localparam int MAX_CHUNKS_DEF = 64;
	localparam int CLAMP_Q10 = 10240;
	localparam logic [31:0] MASS_BUDGET_RST = 32'd65536;
	localparam int SERIES_TERMS = 40;
	localparam int DEMAND_W = 31;
	localparam int SUM_W = 37;

	typedef struct packed {
		logic signed [15:0] error_value;
		logic is_last;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] mass_share;
		logic [5:0] entry_index;
		logic last_of_batch;
	} out_beat_t;
endpackage

### hdl/csmd_ram.sv
// generic single-port-write ram with registered read
module csmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW = 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/clamped_softmax_mass_distributor.sv
// top level of the clamped softmax mass distributor
// Collects a batch of signed Q6.10 error values (clamped above at 10.0), turns each into
// an unsigned Q15.16 demand exp(x) and stores it in a 31-bit wide ram, keeping a running
// sum. The beat marked last ends the batch; then one result beat per stored entry comes out,
// in order: mass budget * demand / sum rounded to nearest, saturated to 32 bits (all zero if
// the sum is zero). Beyond MAX_CHUNKS entries, input beats are dropped, but a last beat still
// closes the batch. One exponential is computed by a single sequencer: a Taylor series,
// each term one 53x11 multiply, then a divide by the term number at four quotient bits a
// cycle (up to 40 terms, usually under 20), then per whole unit of |x| one multiply by e
// (a 64x64 high-half product made of four 32x32 partial products), then a bit-serial
// reciprocal for negative x. Each result beat takes a ram read, one 32x31 multiply, and a
// 32-step restoring divide. After reset the block forms the constant e before in_ready
// first rises. The mass budget may only be written while the block is idle.
`include "clamped_softmax_mass_distributor_defines.svh"
module clamped_softmax_mass_distributor #(
	parameter int MAX_CHUNKS = csmd_pkg::MAX_CHUNKS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input csmd_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output csmd_pkg::out_beat_t out_data,
	input logic cfg_we,
	input logic [31:0] cfg_wdata
);
	import csmd_pkg::*;

	localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

	// sequencer codes
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SER_MUL = 4'd1;
	localparam logic [3:0] ST_SER_DIV = 4'd2;
	localparam logic [3:0] ST_SER_ADD = 4'd3;
	localparam logic [3:0] ST_NORM    = 4'd4;
	localparam logic [3:0] ST_EMUL    = 4'd5;
	localparam logic [3:0] ST_ENORM   = 4'd6;
	localparam logic [3:0] ST_FINAL   = 4'd7;
	localparam logic [3:0] ST_NDIV    = 4'd8;
	localparam logic [3:0] ST_STORE   = 4'd9;
	localparam logic [3:0] ST_RD      = 4'd10;
	localparam logic [3:0] ST_MUL     = 4'd11;
	localparam logic [3:0] ST_DSET    = 4'd12;
	localparam logic [3:0] ST_DIV     = 4'd13;
	localparam logic [3:0] ST_OUT     = 4'd14;

	logic [3:0] state_q;
	logic init_q;              // forming the constant e right after reset
	logic [31:0] mass_budget_q;

	// batch state
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;

	// current input beat
	logic last_q;
	logic neg_q;
	logic [5:0] i_q;           // whole part of |x|
	logic [5:0] n_q;           // multiplies by e still to do

	// series unit
	logic [52:0] term_q;
	logic [53:0] ssum_q;
	logic [10:0] f_q;
	logic [5:0] k_q;
	logic [55:0] sdiv_q;
	logic [55:0] squo_q;
	logic [5:0] srem_q;
	logic [3:0] scnt_q;

	// mantissa and exponent of the running value and of e
	logic [63:0] m_q;
	logic signed [9:0] e_q;
	logic [63:0] bm_q;
	logic signed [9:0] be_q;
	logic [127:0] acc_q;
	logic [1:0] ph_q;

	// reciprocal divider
	logic [63:0] nr_q;
	logic [63:0] nq_q;
	logic [7:0] ncnt_q;
	logic [DEMAND_W-1:0] demand_q;

	// share divider
	logic [63:0] num_q;
	logic [36:0] drem_q;
	logic [31:0] dq_q;
	logic [4:0] dcnt_q;

	logic out_valid_q;
	out_beat_t out_q;
	logic out_load;            // result register takes a new beat

	logic [DEMAND_W-1:0] ram_rdata;
	logic ram_we;

	// input clamp and split of |x|
	logic signed [15:0] q_clamp;
	logic [15:0] q_abs;

	// series combinational pieces
	logic [63:0] ser_prod;
	logic [55:0] squo_nx;
	logic [5:0] srem_nx;
	logic [6:0] sr;
	logic [63:0] ser_norm_m;
	logic signed [9:0] ser_norm_e;

	// partial product
	logic [31:0] pa;
	logic [31:0] pb;
	logic [63:0] pp;
	logic [127:0] pp_sh;
	logic [63:0] mhi;

	// positive rounding
	logic signed [9:0] rs_s;
	logic [6:0] rs_sm1;
	logic [63:0] rs_r;
	logic [DEMAND_W-1:0] pos_demand;

	// negative reciprocal
	logic signed [9:0] nk;
	logic [9:0] nk_p1;
	logic [63:0] nr2;
	logic ntake;
	logic [63:0] nr_nx;
	logic [63:0] nq_nx;
	logic [63:0] nqp;
	logic [DEMAND_W-1:0] neg_demand;

	// share divide
	logic [37:0] dr;
	logic dtake;
	logic [36:0] drem_nx;
	logic [31:0] dq_nx;
	logic [62:0] share_prod;

	assign in_ready = (state_q == ST_IDLE) && !init_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign ram_we = (state_q == ST_STORE);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	assign q_clamp = (in_data.error_value > 16'(CLAMP_Q10)) ? 16'(CLAMP_Q10)
		: in_data.error_value;
	assign q_abs = q_clamp[15] ? 16'(-q_clamp) : q_clamp;

	// term * f / (1024 k): four quotient bits per cycle
	assign ser_prod = 64'(term_q) * 64'(f_q);
	always_comb begin
		srem_nx = srem_q;
		squo_nx = squo_q;
		sr = '0;
		for (int j = 0; j < 4; j++) begin
			sr = {srem_nx, sdiv_q[55-j]};
			if (sr >= {1'b0, k_q}) begin
				sr = sr - {1'b0, k_q};
				squo_nx = {squo_nx[54:0], 1'b1};
			end else begin
				squo_nx = {squo_nx[54:0], 1'b0};
			end
			srem_nx = sr[5:0];
		end
	end

	// the series sum lies in [1, e) so the leading one sits at bit 52 or 53
	assign ser_norm_m = ssum_q[53] ? {ssum_q, 10'b0} : {ssum_q[52:0], 11'b0};
	assign ser_norm_e = ssum_q[53] ? -10'sd62 : -10'sd63;

	// upper half of m * e built from four 32x32 products
	assign pa = ph_q[1] ? m_q[63:32] : m_q[31:0];
	assign pb = ph_q[0] ? bm_q[63:32] : bm_q[31:0];
	assign pp = 64'(pa) * 64'(pb);
	assign pp_sh = {64'b0, pp} << (7'(ph_q[1]) + 7'(ph_q[0])) * 7'd32;
	assign mhi = acc_q[127:64];

	// round m * 2^(e+16) to nearest, ties up
	always_comb begin
		rs_s = -(e_q + 10'sd16);
		rs_sm1 = 7'(rs_s - 10'sd1);
		rs_r = (m_q >> rs_s[6:0]) + 64'((m_q >> rs_sm1) & 64'd1);
		if (rs_s <= 10'sd0) begin
			pos_demand = {DEMAND_W{1'b1}};
		end else if (rs_s > 10'sd64) begin
			pos_demand = '0;
		end else if (rs_s == 10'sd64) begin
			pos_demand = DEMAND_W'((m_q >> 63) & 64'd1);
		end else if (|rs_r[63:31]) begin
			pos_demand = {DEMAND_W{1'b1}};
		end else begin
			pos_demand = rs_r[30:0];
		end
	end

	// 2^(k+1) / m one bit a cycle, keeping the shifted-out carry
	assign nk = 10'sd16 - e_q;
	assign nk_p1 = 10'(nk + 10'sd1);
	assign nr2 = {nr_q[62:0], 1'b0};
	assign ntake = nr_q[63] || (nr2 >= m_q);
	assign nr_nx = ntake ? nr2 - m_q : nr2;
	assign nq_nx = {nq_q[62:0], ntake};
	assign nqp = (nq_nx + 64'd1) >> 1;
	assign neg_demand = (|nqp[63:31]) ? {DEMAND_W{1'b1}} : nqp[30:0];

	// restoring divide of the share numerator by the sum
	assign dr = {drem_q, dq_q[31]};
	assign dtake = dr >= {1'b0, sum_q};
	assign drem_nx = dtake ? 37'(dr - {1'b0, sum_q}) : dr[36:0];
	assign dq_nx = {dq_q[30:0], dtake};
	assign share_prod = 63'(mass_budget_q) * 63'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_budget_q <= MASS_BUDGET_RST;
		end else if (cfg_we) begin
			mass_budget_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SER_MUL;
			init_q <= 1'b1;
			term_q <= 53'(1) << 52;
			ssum_q <= 54'(1) << 52;
			f_q <= 11'd1024;
			k_q <= 6'd1;
			sum_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result beat replaces the one leaving, else valid drops on accept
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !init_q) begin
						last_q <= in_data.is_last;
						neg_q <= q_clamp[15];
						i_q <= q_abs[15:10];
						if (cnt_q < CNT_W'(MAX_CHUNKS)) begin
							f_q <= {1'b0, q_abs[9:0]};
							term_q <= 53'(1) << 52;
							ssum_q <= 54'(1) << 52;
							k_q <= 6'd1;
							state_q <= ST_SER_MUL;
						end else if (in_data.is_last) begin
							// full batch, beat dropped but the batch still closes
							idx_q <= '0;
							state_q <= ST_RD;
						end
					end
				end
				ST_SER_MUL: begin
					sdiv_q <= {3'b0, ser_prod[62:10]};
					srem_q <= '0;
					squo_q <= '0;
					scnt_q <= '0;
					state_q <= ST_SER_DIV;
				end
				ST_SER_DIV: begin
					sdiv_q <= {sdiv_q[51:0], 4'b0};
					srem_q <= srem_nx;
					squo_q <= squo_nx;
					scnt_q <= scnt_q + 4'd1;
					if (scnt_q == 4'd13) begin
						state_q <= ST_SER_ADD;
					end
				end
				ST_SER_ADD: begin
					ssum_q <= ssum_q + 54'(squo_q[52:0]);
					term_q <= squo_q[52:0];
					k_q <= k_q + 6'd1;
					if (squo_q == '0 || k_q == 6'(SERIES_TERMS)) begin
						state_q <= ST_NORM;
					end else begin
						state_q <= ST_SER_MUL;
					end
				end
				ST_NORM: begin
					if (init_q) begin
						bm_q <= ser_norm_m;
						be_q <= ser_norm_e;
						init_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						m_q <= ser_norm_m;
						e_q <= ser_norm_e;
						n_q <= i_q;
						ph_q <= '0;
						state_q <= (i_q == '0) ? ST_FINAL : ST_EMUL;
					end
				end
				ST_EMUL: begin
					acc_q <= (ph_q == 2'd0) ? pp_sh : acc_q + pp_sh;
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						state_q <= ST_ENORM;
					end
				end
				ST_ENORM: begin
					if (mhi[63]) begin
						m_q <= mhi;
						e_q <= e_q + be_q + 10'sd64;
					end else begin
						m_q <= {mhi[62:0], 1'b0};
						e_q <= e_q + be_q + 10'sd63;
					end
					n_q <= n_q - 6'd1;
					state_q <= (n_q == 6'd1) ? ST_FINAL : ST_EMUL;
				end
				ST_FINAL: begin
					if (!neg_q) begin
						demand_q <= pos_demand;
						state_q <= ST_STORE;
					end else if (nk < 10'sd62) begin
						demand_q <= '0;
						state_q <= ST_STORE;
					end else begin
						nr_q <= 64'd1;
						nq_q <= '0;
						ncnt_q <= nk_p1[7:0];
						state_q <= ST_NDIV;
					end
				end
				ST_NDIV: begin
					nr_q <= nr_nx;
					nq_q <= nq_nx;
					ncnt_q <= ncnt_q - 8'd1;
					if (ncnt_q == 8'd1) begin
						demand_q <= neg_demand;
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					sum_q <= sum_q + SUM_W'(demand_q);
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_q) begin
						idx_q <= '0;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					num_q <= 64'(share_prod) + 64'(sum_q >> 1);
					state_q <= ST_DSET;
				end
				ST_DSET: begin
					if (sum_q == '0) begin
						dq_q <= '0;
						state_q <= ST_OUT;
					end else if ({5'b0, num_q[63:32]} >= sum_q) begin
						// quotient needs more than 32 bits
						dq_q <= '1;
						state_q <= ST_OUT;
					end else begin
						drem_q <= {5'b0, num_q[63:32]};
						dq_q <= num_q[31:0];
						dcnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					drem_q <= drem_nx;
					dq_q <= dq_nx;
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd31) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_q.mass_share <= dq_q;
						out_q.entry_index <= 6'(idx_q);
						out_q.last_of_batch <= (idx_q == cnt_q - CNT_W'(1));
						if (idx_q == cnt_q - CNT_W'(1)) begin
							sum_q <= '0;
							cnt_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// demand store, written at the fill position, read at the result position
	csmd_ram #(
		.WIDTH(DEMAND_W),
		.DEPTH(MAX_CHUNKS),
		.AW(AW)
	) u_demand_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(demand_q),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// fill count never passes the store depth
	`CSMD_ASSERT(a_cnt_max, cnt_q <= CNT_W'(MAX_CHUNKS), "entry count beyond store depth")
	// an empty batch carries no sum
	`CSMD_ASSERT_IMP(a_sum_empty, cnt_q == '0, sum_q == '0, "sum nonzero with no entries")
	// result beats only for stored entries
	`CSMD_ASSERT_IMP(a_idx_range, state_q == ST_OUT, idx_q < cnt_q, "result index past fill")
endmodule
